// ===== rtl/core/catmull_rom_point_window_macros.svh =====
// assertion macros for the point window block
`ifndef CATMULL_ROM_POINT_WINDOW_MACROS_SVH
`define CATMULL_ROM_POINT_WINDOW_MACROS_SVH

`ifndef SYNTHESIS
`define CRPW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crpw check failed");
`define CRPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crpw check failed");
`else
`define CRPW_ASSERT_NOW(label, clk, rst, ante, cons)
`define CRPW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/crpw_pkg.sv =====
`default_nettype none

package crpw_pkg;

  localparam int PosW = 18;

  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_INTERP = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [PosW-1:0]    position;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               range_error;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

endpackage

`default_nettype wire

// ===== rtl/core/crpw_mul.sv =====
`default_nettype none

// shared signed multiplier, product registered
module crpw_mul #(
  parameter int OpW = 19
) (
  input  wire                        clk,
  input  wire  signed [OpW-1:0]      a,
  input  wire  signed [OpW-1:0]      b,
  output logic signed [2*OpW-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/crpw_window.sv =====
`default_nettype none

// circular point store: logical index 0 is the oldest point
module crpw_window #(
  parameter int WINDOW_DEPTH = 4,
  localparam int IdxW = $clog2(WINDOW_DEPTH)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  crpw_pkg::point_t       wr_point,
  input  wire                    rd_en,
  input  wire  [IdxW-1:0]        rd_idx,
  output crpw_pkg::point_t       rd_point
);

  logic [IdxW-1:0]         wptr;
  logic [IdxW-1:0]         wptr_next;
  logic [WINDOW_DEPTH-1:0] valid;
  logic [IdxW:0]           sum;
  logic [IdxW:0]           sum_wrap;
  logic [IdxW-1:0]         phys;
  crpw_pkg::point_t        mem [WINDOW_DEPTH];
  crpw_pkg::point_t        rd_q;
  logic                    rd_ok;

  always_comb begin
    sum      = {1'b0, wptr} + {1'b0, rd_idx};
    sum_wrap = sum - (IdxW+1)'(WINDOW_DEPTH);
    if (sum >= (IdxW+1)'(WINDOW_DEPTH)) begin
      phys = sum_wrap[IdxW-1:0];
    end else begin
      phys = sum[IdxW-1:0];
    end
    if (wptr == IdxW'(WINDOW_DEPTH - 1)) begin
      wptr_next = '0;
    end else begin
      wptr_next = wptr + IdxW'(1);
    end
  end

  // the oldest slot takes the new point, which becomes the newest
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      valid <= '0;
    end else if (push) begin
      valid[wptr] <= 1'b1;
      wptr        <= wptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_point;
    end
    if (rd_en) begin
      rd_q  <= mem[phys];
      rd_ok <= valid[phys];
    end
  end

  // never written since reset reads as the origin
  assign rd_point = rd_ok ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/catmull_rom_point_window.sv =====
// channel | valid        | stall        | payload
// in      | item_valid   | item_stall   | item   (crpw_pkg::item_t)
// out     | result_valid | result_stall | result (crpw_pkg::result_t)
//
// a push leaves the block idle and the next item may follow at once.
// an interpolate holds item_stall high from accept until it is done: ten products
// go one after another through the single multiplier, window points are read
// one a cycle from the point store. a segment out of range skips the products
// and goes from accept straight to the done state.
// rst is synchronous and empties the window to all-zero points.
// a waiting result does not block a push; a finished interpolate holds until
// the output register is free.
`default_nettype none
`include "catmull_rom_point_window_macros.svh"

module catmull_rom_point_window #(
  parameter int WINDOW_DEPTH = 4,
  parameter int FRAC_BITS    = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  crpw_pkg::item_t    item,
  output logic               result_valid,
  input  wire                result_stall,
  output crpw_pkg::result_t  result
);

  localparam int IdxW  = $clog2(WINDOW_DEPTH);
  localparam int HW    = FRAC_BITS + 3;
  localparam int OpW   = (HW > 16) ? HW : 16;
  localparam int PW    = 2 * OpW;
  localparam int TermW = 20;
  localparam int AccW  = 22;
  localparam int PosW  = crpw_pkg::PosW;

  localparam logic signed [HW-1:0]   ScaleS = HW'(2 ** FRAC_BITS);
  localparam logic signed [PW-1:0]   RoundS = PW'(2 ** FRAC_BITS - 1);
  localparam logic signed [AccW-1:0] SatHi  = AccW'(32767);
  localparam logic signed [AccW-1:0] SatLo  = AccW'(-32768);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_CUBE  = 4'd2;
  localparam logic [3:0] S_BASIS = 4'd3;
  localparam logic [3:0] S_PT2   = 4'd4;
  localparam logic [3:0] S_TAN   = 4'd5;
  localparam logic [3:0] S_MAC   = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [1:0] TERM_P0 = 2'd0;
  localparam logic [1:0] TERM_M0 = 2'd1;
  localparam logic [1:0] TERM_P1 = 2'd2;
  localparam logic [1:0] TERM_M1 = 2'd3;

  function automatic logic signed [15:0] half_diff(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
    logic signed [16:0] d;
    logic signed [16:0] h;
    d = $signed({a[15], a}) - $signed({b[15], b});
    h = (d + $signed({16'b0, d[16]})) >>> 1;
    return h[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
    logic signed [15:0] r;
    if (v > SatHi) begin
      r = 16'sh7fff;
    end else if (v < SatLo) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [3:0]                   state;
  logic [FRAC_BITS-1:0]         frac;
  logic [IdxW-1:0]              seg;
  logic                         err;
  logic [FRAC_BITS-1:0]         t2;
  logic signed [HW-1:0]         h00, h10, h01, h11;
  crpw_pkg::point_t             pm1, p0, p1;
  logic signed [15:0]           mx0, mx1, my0, my1;
  logic [2:0]                   cnt;
  logic                         prod_live, prod_ax;
  logic signed [TermW-1:0]      term;
  logic                         term_live, term_ax;
  logic signed [AccW-1:0]       acc_x, acc_y;

  logic                         accept;
  logic [FRAC_BITS+PosW-1:0]    pos_ext;
  logic [PosW-1:0]              seg_full;
  logic [PosW:0]                seg_top;
  logic                         seg_bad;
  logic                         push;
  crpw_pkg::point_t             wr_point;
  logic                         rd_en;
  logic [IdxW-1:0]              rd_idx;
  crpw_pkg::point_t             rd_point;
  logic signed [OpW-1:0]        mul_a, mul_b;
  logic signed [PW-1:0]         prod;
  logic [FRAC_BITS-1:0]         prod_hi;
  logic signed [HW-1:0]         t2s, t3s, ts;
  logic signed [PW-1:0]         scaled;
  logic signed [15:0]           op_pt;
  logic signed [HW-1:0]         op_h;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  assign pos_ext  = {{FRAC_BITS{1'b0}}, item.position};
  assign seg_full = item.position >> FRAC_BITS;
  assign seg_top  = {1'b0, seg_full} + (PosW+1)'(2);
  assign seg_bad  = (seg_full == '0) || (seg_top >= (PosW+1)'(WINDOW_DEPTH));

  assign push     = accept && (item.cmd == crpw_pkg::CMD_PUSH);
  assign wr_point = '{x: item.new_x, y: item.new_y};

  always_comb begin
    rd_en  = 1'b1;
    rd_idx = seg;
    case (state)
      S_SQ:    rd_idx = seg - IdxW'(1);
      S_CUBE:  rd_idx = seg;
      S_BASIS: rd_idx = seg + IdxW'(1);
      S_PT2:   rd_idx = seg + IdxW'(2);
      default: rd_en  = 1'b0;
    endcase
  end

  crpw_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_point (wr_point),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_point (rd_point)
  );

  assign prod_hi = prod[2*FRAC_BITS-1:FRAC_BITS];

  // point or tangent and its basis weight; upper counter bit picks the axis
  always_comb begin
    case (cnt[1:0])
      TERM_P0: begin
        op_pt = cnt[2] ? p0.y : p0.x;
        op_h  = h00;
      end
      TERM_M0: begin
        op_pt = cnt[2] ? my0 : mx0;
        op_h  = h10;
      end
      TERM_P1: begin
        op_pt = cnt[2] ? p1.y : p1.x;
        op_h  = h01;
      end
      TERM_M1: begin
        op_pt = cnt[2] ? my1 : mx1;
        op_h  = h11;
      end
      default: begin
        op_pt = '0;
        op_h  = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_SQ: begin
        mul_a = $signed({{(OpW-FRAC_BITS){1'b0}}, frac});
        mul_b = $signed({{(OpW-FRAC_BITS){1'b0}}, frac});
      end
      S_CUBE: begin
        mul_a = $signed({{(OpW-FRAC_BITS){1'b0}}, prod_hi});
        mul_b = $signed({{(OpW-FRAC_BITS){1'b0}}, frac});
      end
      S_MAC: begin
        mul_a = OpW'(op_pt);
        mul_b = OpW'(op_h);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  crpw_mul #(
    .OpW(OpW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign t2s = $signed({3'b000, t2});
  assign t3s = $signed({3'b000, prod_hi});
  assign ts  = $signed({3'b000, frac});

  // division by the scale truncating toward zero
  assign scaled = (prod + (prod[PW-1] ? RoundS : '0)) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      prod_live    <= 1'b0;
      term_live    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      prod_live <= (state == S_MAC);
      term_live <= prod_live;
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && item.cmd == crpw_pkg::CMD_INTERP) begin
            state <= seg_bad ? S_DONE : S_SQ;
          end
        end
        S_SQ:    state <= S_CUBE;
        S_CUBE:  state <= S_BASIS;
        S_BASIS: state <= S_PT2;
        S_PT2:   state <= S_TAN;
        S_TAN: begin
          cnt   <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!prod_live && !term_live) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frac <= pos_ext[FRAC_BITS-1:0];
      seg  <= seg_full[IdxW-1:0];
      err  <= seg_bad;
    end
    if (state == S_CUBE) begin
      t2  <= prod_hi;
      pm1 <= rd_point;
    end
    if (state == S_BASIS) begin
      h00 <= (t3s <<< 1) - ((t2s <<< 1) + t2s) + ScaleS;
      h10 <= t3s - (t2s <<< 1) + ts;
      h01 <= ((t2s <<< 1) + t2s) - (t3s <<< 1);
      h11 <= t3s - t2s;
      p0  <= rd_point;
    end
    if (state == S_PT2) begin
      p1 <= rd_point;
    end
    if (state == S_TAN) begin
      mx0   <= half_diff(p1.x, pm1.x);
      my0   <= half_diff(p1.y, pm1.y);
      mx1   <= half_diff(rd_point.x, p0.x);
      my1   <= half_diff(rd_point.y, p0.y);
      acc_x <= '0;
      acc_y <= '0;
    end
    prod_ax <= cnt[2];
    if (prod_live) begin
      term    <= scaled[TermW-1:0];
      term_ax <= prod_ax;
    end
    if (term_live) begin
      if (term_ax) begin
        acc_y <= acc_y + AccW'(term);
      end else begin
        acc_x <= acc_x + AccW'(term);
      end
    end
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      if (err) begin
        result <= '{out_x: '0, out_y: '0, range_error: 1'b1};
      end else begin
        result <= '{out_x: sat16(acc_x), out_y: sat16(acc_y), range_error: 1'b0};
      end
    end
  end

  `CRPW_ASSERT_NEXT(a_push_stays_idle, clk, rst, accept && item.cmd == crpw_pkg::CMD_PUSH, state == S_IDLE)
  `CRPW_ASSERT_NOW(a_err_zero, clk, rst, result_valid && result.range_error, result.out_x == '0 && result.out_y == '0)
  `CRPW_ASSERT_NOW(a_rose_from_done, clk, rst, $rose(result_valid), $past(state) == S_DONE)
  `CRPW_ASSERT_NOW(a_done_drained, clk, rst, state == S_DONE, !prod_live && !term_live)

endmodule

`default_nettype wire
